@@ hw/rtl/mctd_pkg.sv @@
// Shared types, constants and saturating arithmetic helpers for the
// matrix chain trace derivative block. No dependencies.
package mctd_pkg;

  localparam int MAX_STATES = 4;
  localparam int MAX_BEADS  = 8;

  localparam int IDX_W  = $clog2(MAX_STATES);
  localparam int BEAD_W = $clog2(MAX_BEADS);
  localparam int NW     = $clog2(MAX_STATES + 1);
  localparam int NBW    = $clog2(MAX_BEADS + 1);
  localparam int ELEMS  = MAX_STATES * MAX_STATES;
  localparam int MEM_D  = MAX_BEADS * ELEMS;
  localparam int MEM_AW = BEAD_W + 2 * IDX_W;
  localparam int SAW    = 2 * IDX_W;

  // wait after the last operand issue until every cell result is written back
  localparam int DRAIN_CYC = MAX_STATES + 6;
  localparam int DW        = $clog2(DRAIN_CYC + 1);

  localparam logic [1:0] FUNC_C  = 2'd0;
  localparam logic [1:0] FUNC_M  = 2'd1;
  localparam logic [1:0] FUNC_DM = 2'd2;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] HALF_LSB = 64'sd32768;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BEAD_W-1:0] bead_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         bead_index;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] elem_re;
    logic signed [31:0] elem_im;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] trace_re;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cpx_t;

  // operand element travelling down the cell row
  typedef struct packed {
    logic               vld;
    idx_t               row;
    idx_t               kk;
    logic               first;
    logic               lastk;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } a_elem_t;

  // right-hand operand element broadcast into the cells
  typedef struct packed {
    logic               vld;
    idx_t               kk;
    idx_t               col;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } bload_t;

  typedef struct packed {
    logic               vld;
    idx_t               row;
    idx_t               col;
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic               of_re;
    logic               of_im;
  } cres_t;

  typedef enum logic [2:0] {
    SRC_C, SRC_M, SRC_DM, SRC_P, SRC_T, SRC_S
  } src_e;

  typedef enum logic [1:0] {
    DST_T, DST_P, DST_S, DST_SUM
  } dst_e;

  typedef struct packed {
    logic  vld;
    dst_e  dst;
    bead_t bead;
    idx_t  row;
    idx_t  col;
    cpx_t  data;
  } wreq_t;

  typedef enum logic [2:0] {
    OP_MC, OP_PT, OP_PD, OP_TS_SUM, OP_CM, OP_TS_S
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOADB, ST_FEED, ST_DRAIN, ST_NEXT, ST_TRACE, ST_OUT
  } state_e;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } q16_t;

  function automatic sat_t sat_add(input logic signed [63:0] a,
                                   input logic signed [63:0] b);
    logic [64:0] s;
    sat_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    if (r.ovf) begin
      r.val = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r.val = s[63:0];
    end
    return r;
  endfunction

  // round Q32.32 to Q16.16: add half an LSB, floor, clamp to 32 bits
  function automatic q16_t to_q16(input logic signed [63:0] v);
    sat_t s;
    logic [47:0] q;
    logic clamp;
    q16_t r;
    s = sat_add(v, HALF_LSB);
    q = s.val[63:16];
    clamp = !((&q[47:31]) || !(|q[47:31]));
    if (clamp) begin
      r.val = q[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r.val = q[31:0];
    end
    r.ovf = s.ovf | clamp;
    return r;
  endfunction

endpackage

@@ hw/rtl/matrix_chain_trace_derivative.sv @@
// Top level: element stores, chain sequencer, cell row and write-back.
// Depends on mctd_pkg, mctd_cell and mctd_wb.
//
// Elements are stored one per accepted transaction with a C, M or dM function
// code. A transaction with last set starts the chain; in_stall stays high until
// the result is handed to the output register. With n states and nb beads the
// run is 2*(nb-1) + 4*nb - 2 matrix products, each an operand load into the
// cell row, then row streaming through it, then drain and step; trace
// summation over the n diagonal entries follows. The single read port of the
// element stores has each phase read its n*n elements one at a time.
module matrix_chain_trace_derivative (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mctd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mctd_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mctd_pkg::*;

  // stores
  cpx_t c_mem  [MEM_D];
  cpx_t m_mem  [MEM_D];
  cpx_t dm_mem [MEM_D];
  cpx_t p_mem  [MEM_D];
  cpx_t t_mem  [ELEMS];
  cpx_t s_mem  [ELEMS];
  cpx_t c_rd_r, m_rd_r, dm_rd_r, p_rd_r, t_rd_r, s_rd_r;

  // config
  logic [2:0] st_cfg_r;
  logic [3:0] bd_cfg_r;

  // control
  state_e            state_r, state_nxt;
  op_e               op_r, op_nxt;
  bead_t             k_r, k_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NBW-1:0]    nb_r, nb_nxt;
  logic              id_r, id_nxt;
  idx_t              r_cnt_r, r_cnt_nxt, c_cnt_r, c_cnt_nxt;
  logic [DW-1:0]     drain_r, drain_nxt;
  logic signed [63:0] tr_r, tr_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              sum_clr;

  // read issue
  src_e              rsrc, rsrc_r;
  logic              rld, rld_r, rfeed, rfeed_r;
  logic              rfirst_r, rlast_r;
  idx_t              rrow_r, rcol_r;
  bead_t             rbead;
  logic [MEM_AW-1:0] raddr;
  logic [SAW-1:0]    saddr;
  cpx_t              rd_data;

  // operand decode
  src_e  a_src, b_src;
  bead_t a_bead, b_bead, dst_bead;
  dst_e  dst;

  idx_t              nm1;
  bead_t             nbm1;
  logic [NW-1:0]     n_eff;
  logic [NBW-1:0]    nb_eff;
  logic              accept, in_ok;
  logic [MEM_AW-1:0] waddr;
  sat_t              tr_add;

  a_elem_t feed;
  bload_t  bld;
  a_elem_t a_chain [MAX_STATES];
  cres_t   cres    [MAX_STATES];
  wreq_t   wreq;
  logic    ovf_set;
  logic signed [63:0] diag_val;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(bd_cfg_r) : 32'(st_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_cfg_r <= 3'd4;
      bd_cfg_r <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        bd_cfg_r <= pwdata[3:0];
      end else begin
        st_cfg_r <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (st_cfg_r == 3'd0) begin
      n_eff = NW'(1);
    end else if (32'(st_cfg_r) > MAX_STATES) begin
      n_eff = NW'(MAX_STATES);
    end else begin
      n_eff = NW'(st_cfg_r);
    end
    if (bd_cfg_r == 4'd0) begin
      nb_eff = NBW'(1);
    end else if (32'(bd_cfg_r) > MAX_BEADS) begin
      nb_eff = NBW'(MAX_BEADS);
    end else begin
      nb_eff = NBW'(bd_cfg_r);
    end
  end

  // element loading
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_ok    = 32'(in_data.bead_index) < MAX_BEADS
                    && 32'(in_data.row_index) < MAX_STATES
                    && 32'(in_data.col_index) < MAX_STATES;
  assign waddr    = {in_data.bead_index[BEAD_W-1:0], in_data.row_index[IDX_W-1:0],
                     in_data.col_index[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (accept && in_ok) begin
      unique case (in_data.func)
        FUNC_C:  c_mem[waddr]  <= '{re: in_data.elem_re, im: in_data.elem_im};
        FUNC_M:  m_mem[waddr]  <= '{re: in_data.elem_re, im: in_data.elem_im};
        FUNC_DM: dm_mem[waddr] <= '{re: in_data.elem_re, im: in_data.elem_im};
        default: ;
      endcase
    end
    if (wreq.vld) begin
      unique case (wreq.dst)
        DST_T:   t_mem[{wreq.row, wreq.col}] <= wreq.data;
        DST_P:   p_mem[{wreq.bead, wreq.row, wreq.col}] <= wreq.data;
        DST_S:   s_mem[{wreq.row, wreq.col}] <= wreq.data;
        default: ;
      endcase
    end
    c_rd_r  <= c_mem[raddr];
    m_rd_r  <= m_mem[raddr];
    dm_rd_r <= dm_mem[raddr];
    p_rd_r  <= p_mem[raddr];
    t_rd_r  <= t_mem[saddr];
    s_rd_r  <= s_mem[saddr];
  end

  // operands of the current product; prefix of bead 0 is C of bead 0
  always_comb begin
    a_src = SRC_T;  a_bead = k_r;
    b_src = SRC_S;  b_bead = k_r;
    dst   = DST_T;  dst_bead = k_r;
    unique case (op_r)
      OP_MC: begin
        a_src = SRC_M;  a_bead = k_r - BEAD_W'(1);
        b_src = SRC_C;
      end
      OP_PT: begin
        a_src = SRC_P;  a_bead = k_r - BEAD_W'(1);
        b_src = SRC_T;
        dst   = DST_P;
      end
      OP_PD: begin
        a_src = SRC_P;
        b_src = SRC_DM;
      end
      OP_TS_SUM: dst = DST_SUM;
      OP_CM: begin
        a_src = SRC_C;
        b_src = SRC_M;
      end
      OP_TS_S: dst = DST_S;
      default: ;
    endcase
    if (a_src == SRC_P && a_bead == '0) begin
      a_src = SRC_C;
    end
  end

  assign nm1  = IDX_W'(n_r - NW'(1));
  assign nbm1 = BEAD_W'(nb_r - NBW'(1));

  always_comb begin
    rld   = (state_r == ST_LOADB);
    rfeed = (state_r == ST_FEED);
    rsrc  = rld ? b_src : a_src;
    rbead = rld ? b_bead : a_bead;
    raddr = {rbead, r_cnt_r, c_cnt_r};
    saddr = {r_cnt_r, c_cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rld_r   <= 1'b0;
      rfeed_r <= 1'b0;
    end else begin
      rld_r   <= rld;
      rfeed_r <= rfeed;
    end
  end

  always_ff @(posedge clk) begin
    rsrc_r   <= rsrc;
    rrow_r   <= r_cnt_r;
    rcol_r   <= c_cnt_r;
    rfirst_r <= (c_cnt_r == '0);
    rlast_r  <= (c_cnt_r == nm1);
  end

  always_comb begin
    unique case (rsrc_r)
      SRC_C:   rd_data = c_rd_r;
      SRC_M:   rd_data = m_rd_r;
      SRC_DM:  rd_data = dm_rd_r;
      SRC_P:   rd_data = p_rd_r;
      SRC_T:   rd_data = t_rd_r;
      SRC_S: begin
        if (id_r) begin
          rd_data.re = (rrow_r == rcol_r) ? Q_ONE : 32'sd0;
          rd_data.im = 32'sd0;
        end else begin
          rd_data = s_rd_r;
        end
      end
      default: rd_data = '0;
    endcase
    feed.vld   = rfeed_r;
    feed.row   = rrow_r;
    feed.kk    = rcol_r;
    feed.first = rfirst_r;
    feed.lastk = rlast_r;
    feed.re    = rd_data.re;
    feed.im    = rd_data.im;
    bld.vld    = rld_r;
    bld.kk     = rrow_r;
    bld.col    = rcol_r;
    bld.re     = rd_data.re;
    bld.im     = rd_data.im;
  end

  // cell row: operand elements step one cell per cycle
  for (genvar j = 0; j < MAX_STATES; j++) begin : g_cell
    mctd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(j)),
      .a_in     ((j == 0) ? feed : a_chain[(j == 0) ? 0 : j - 1]),
      .b_ld     (bld),
      .a_out    (a_chain[j]),
      .res      (cres[j])
    );
  end

  mctd_wb u_wb (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (cres),
    .n_use    (n_r),
    .dst      (dst),
    .dst_bead (dst_bead),
    .sum_clr  (sum_clr),
    .diag_idx (r_cnt_r),
    .wreq     (wreq),
    .ovf_set  (ovf_set),
    .diag_val (diag_val)
  );

  assign tr_add = sat_add(tr_r, diag_val);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    nb_nxt        = nb_r;
    id_nxt        = id_r;
    r_cnt_nxt     = r_cnt_r;
    c_cnt_nxt     = c_cnt_r;
    drain_nxt     = drain_r;
    tr_nxt        = tr_r;
    ovf_nxt       = ovf_r | ovf_set;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    sum_clr       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.last) begin
          n_nxt     = n_eff;
          nb_nxt    = nb_eff;
          id_nxt    = 1'b1;
          ovf_nxt   = 1'b0;
          tr_nxt    = '0;
          sum_clr   = 1'b1;
          r_cnt_nxt = '0;
          c_cnt_nxt = '0;
          if (nb_eff > NBW'(1)) begin
            op_nxt = OP_MC;
            k_nxt  = BEAD_W'(1);
          end else begin
            op_nxt = OP_PD;
            k_nxt  = '0;
          end
          state_nxt = ST_LOADB;
        end
      end
      ST_LOADB, ST_FEED: begin
        if (c_cnt_r == nm1) begin
          c_cnt_nxt = '0;
          if (r_cnt_r == nm1) begin
            r_cnt_nxt = '0;
            drain_nxt = '0;
            state_nxt = (state_r == ST_LOADB) ? ST_FEED : ST_DRAIN;
          end else begin
            r_cnt_nxt = r_cnt_r + IDX_W'(1);
          end
        end else begin
          c_cnt_nxt = c_cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + DW'(1);
        if (drain_r == DW'(DRAIN_CYC - 1)) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_nxt = ST_LOADB;
        unique case (op_r)
          OP_MC: op_nxt = OP_PT;
          OP_PT: begin
            if (k_r == nbm1) begin
              op_nxt = OP_PD;
            end else begin
              op_nxt = OP_MC;
              k_nxt  = k_r + BEAD_W'(1);
            end
          end
          OP_PD: op_nxt = OP_TS_SUM;
          OP_TS_SUM: begin
            if (k_r == '0) begin
              state_nxt = ST_TRACE;
            end else begin
              op_nxt = OP_CM;
            end
          end
          OP_CM: op_nxt = OP_TS_S;
          OP_TS_S: begin
            op_nxt = OP_PD;
            k_nxt  = k_r - BEAD_W'(1);
            id_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      ST_TRACE: begin
        tr_nxt  = tr_add.val;
        ovf_nxt = ovf_r | tr_add.ovf;
        if (r_cnt_r == nm1) begin
          r_cnt_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          r_cnt_nxt = r_cnt_r + IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.trace_re = tr_r;
          out_data_nxt.overflow = ovf_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      r_cnt_r     <= '0;
      c_cnt_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      r_cnt_r     <= r_cnt_nxt;
      c_cnt_r     <= c_cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    nb_r       <= nb_nxt;
    id_r       <= id_nxt;
    drain_r    <= drain_nxt;
    tr_r       <= tr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/mctd_cell.sv @@
// One cell of the multiply row: holds one column of the right-hand operand
// and accumulates one output column. Depends on mctd_pkg.
module mctd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mctd_pkg::idx_t    cell_idx,
  input  mctd_pkg::a_elem_t a_in,
  input  mctd_pkg::bload_t  b_ld,
  output mctd_pkg::a_elem_t a_out,
  output mctd_pkg::cres_t   res
);
  import mctd_pkg::*;

  a_elem_t a_r;
  logic signed [31:0] b_re_r [MAX_STATES];
  logic signed [31:0] b_im_r [MAX_STATES];

  logic               p_vld_r, p_first_r, p_last_r;
  idx_t               p_row_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  logic signed [63:0] acc_re_r, acc_im_r;
  logic               acc_of_re_r, acc_of_im_r;
  cres_t              res_r;

  logic signed [31:0] b_re, b_im;
  logic signed [63:0] base_re, base_im;
  logic               base_of_re, base_of_im;
  sat_t               s1_re, s2_re, s1_im, s2_im;

  always_comb begin
    b_re = b_re_r[a_r.kk];
    b_im = b_im_r[a_r.kk];
    base_re    = p_first_r ? 64'sd0 : acc_re_r;
    base_im    = p_first_r ? 64'sd0 : acc_im_r;
    base_of_re = p_first_r ? 1'b0 : acc_of_re_r;
    base_of_im = p_first_r ? 1'b0 : acc_of_im_r;
    s1_re = sat_add(base_re, p_rr_r);
    s2_re = sat_add(s1_re.val, -p_ii_r);
    s1_im = sat_add(base_im, p_ri_r);
    s2_im = sat_add(s1_im.val, p_ir_r);
  end

  always_ff @(posedge clk) begin
    if (b_ld.vld && b_ld.col == cell_idx) begin
      b_re_r[b_ld.kk] <= b_ld.re;
      b_im_r[b_ld.kk] <= b_ld.im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld   <= 1'b0;
      p_vld_r   <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      a_r     <= a_in;
      p_vld_r <= a_r.vld;
      res_r.vld   <= p_vld_r && p_last_r;
      res_r.row   <= p_row_r;
      res_r.col   <= cell_idx;
      res_r.re    <= s2_re.val;
      res_r.im    <= s2_im.val;
      res_r.of_re <= base_of_re | s1_re.ovf | s2_re.ovf;
      res_r.of_im <= base_of_im | s1_im.ovf | s2_im.ovf;
    end
  end

  always_ff @(posedge clk) begin
    p_first_r <= a_r.first;
    p_last_r  <= a_r.lastk;
    p_row_r   <= a_r.row;
    p_rr_r    <= a_r.re * b_re;
    p_ii_r    <= a_r.im * b_im;
    p_ri_r    <= a_r.re * b_im;
    p_ir_r    <= a_r.im * b_re;
    if (p_vld_r) begin
      acc_re_r    <= s2_re.val;
      acc_im_r    <= s2_im.val;
      acc_of_re_r <= base_of_re | s1_re.ovf | s2_re.ovf;
      acc_of_im_r <= base_of_im | s1_im.ovf | s2_im.ovf;
    end
  end

  assign a_out = a_r;
  assign res   = res_r;

endmodule

@@ hw/rtl/mctd_wb.sv @@
// Write-back of cell results: Q16.16 rounding into a matrix store, or
// accumulation into the real-part sum array. Depends on mctd_pkg.
module mctd_wb (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mctd_pkg::cres_t        res [mctd_pkg::MAX_STATES],
  input  logic [mctd_pkg::NW-1:0] n_use,
  input  mctd_pkg::dst_e         dst,
  input  mctd_pkg::bead_t        dst_bead,
  input  logic                   sum_clr,
  input  mctd_pkg::idx_t         diag_idx,
  output mctd_pkg::wreq_t        wreq,
  output logic                   ovf_set,
  output logic signed [63:0]     diag_val
);
  import mctd_pkg::*;

  cres_t              sel, sel_r;
  logic signed [63:0] sum_r [ELEMS];
  logic [ELEMS-1:0]   sum_vld_r;
  logic [SAW-1:0]     sidx, didx;
  logic signed [63:0] old;
  sat_t               sa;
  q16_t               q_re, q_im;

  // cells finish in distinct cycles, so at most one result is valid here
  always_comb begin
    sel = '0;
    for (int j = 0; j < MAX_STATES; j++) begin
      if (res[j].vld && NW'(res[j].col) < n_use) begin
        sel = res[j];
      end
    end
  end

  always_comb begin
    sidx = {sel_r.row, sel_r.col};
    didx = {diag_idx, diag_idx};
    old  = sum_vld_r[sidx] ? sum_r[sidx] : 64'sd0;
    sa   = sat_add(old, sel_r.re);
    q_re = to_q16(sel_r.re);
    q_im = to_q16(sel_r.im);
    wreq.vld     = sel_r.vld && dst != DST_SUM;
    wreq.dst     = dst;
    wreq.bead    = dst_bead;
    wreq.row     = sel_r.row;
    wreq.col     = sel_r.col;
    wreq.data.re = q_re.val;
    wreq.data.im = q_im.val;
    if (dst == DST_SUM) begin
      ovf_set = sel_r.vld && (sel_r.of_re || sa.ovf);
    end else begin
      ovf_set = sel_r.vld && (sel_r.of_re || sel_r.of_im || q_re.ovf || q_im.ovf);
    end
    diag_val = sum_vld_r[didx] ? sum_r[didx] : 64'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r.vld <= 1'b0;
      sum_vld_r <= '0;
    end else begin
      sel_r <= sel;
      if (sum_clr) begin
        sum_vld_r <= '0;
      end else if (sel_r.vld && dst == DST_SUM) begin
        sum_vld_r[sidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_r.vld && dst == DST_SUM) begin
      sum_r[sidx] <= sa.val;
    end
  end

endmodule

@@ bench/mctd_checker.sv @@
// Checker for matrix_chain_trace_derivative: tracks the register writes and the
// element loads, predicts each trace result and compares it on the result port.
// Depends on mctd_pkg for the transaction types and the built sizes.
module mctd_checker
  import mctd_pkg::*;
#(
  parameter logic [2:0] ADDR_STATES = 3'd0,
  parameter logic [2:0] ADDR_BEADS  = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int re;
    int im;
  } cx_t;
  typedef cx_t mat_t[ELEMS];

  mat_t c_mem[MAX_BEADS];
  mat_t m_mem[MAX_BEADS];
  mat_t dm_mem[MAX_BEADS];
  longint real_sum[ELEMS];
  int unsigned dim_reg;
  int unsigned bead_reg;
  bit sat_seen;
  out_item_t trace_q[$];

  function automatic longint clamp_add(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  // subtraction saturates on the exact difference, same as the add
  function automatic longint clamp_sub(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic int round_q16(longint v);
    longint r;
    r = clamp_add(v, 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (r < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(r);
  endfunction

  function automatic void cmat_mul(input mat_t a, input mat_t b, input int n,
                                   output mat_t r);
    longint acc_re, acc_im;
    for (int i = 0; i < ELEMS; i++) begin
      r[i].re = 0;
      r[i].im = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < n; k++) begin
          acc_re = clamp_add(acc_re, longint'(a[i*MAX_STATES+k].re) * b[k*MAX_STATES+j].re);
          acc_re = clamp_sub(acc_re, longint'(a[i*MAX_STATES+k].im) * b[k*MAX_STATES+j].im);
          acc_im = clamp_add(acc_im, longint'(a[i*MAX_STATES+k].re) * b[k*MAX_STATES+j].im);
          acc_im = clamp_add(acc_im, longint'(a[i*MAX_STATES+k].im) * b[k*MAX_STATES+j].re);
        end
        r[i*MAX_STATES+j].re = round_q16(acc_re);
        r[i*MAX_STATES+j].im = round_q16(acc_im);
      end
    end
  endfunction

  // real part of a*b, kept in Q32.32 and added into the running sum
  function automatic void add_real_part(input mat_t a, input mat_t b, input int n);
    longint acc_re;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc_re = 0;
        for (int k = 0; k < n; k++) begin
          acc_re = clamp_add(acc_re, longint'(a[i*MAX_STATES+k].re) * b[k*MAX_STATES+j].re);
          acc_re = clamp_sub(acc_re, longint'(a[i*MAX_STATES+k].im) * b[k*MAX_STATES+j].im);
        end
        real_sum[i*MAX_STATES+j] = clamp_add(real_sum[i*MAX_STATES+j], acc_re);
      end
    end
  endfunction

  function automatic out_item_t chain_trace();
    int n, nb;
    mat_t fwd[MAX_BEADS];
    mat_t bwd, t, u;
    longint tr;
    out_item_t res;
    n = (dim_reg < 1) ? 1 : (dim_reg > MAX_STATES) ? MAX_STATES : int'(dim_reg);
    nb = (bead_reg < 1) ? 1 : (bead_reg > MAX_BEADS) ? MAX_BEADS : int'(bead_reg);
    sat_seen = 1'b0;
    tr = 0;
    for (int i = 0; i < ELEMS; i++) real_sum[i] = 0;
    fwd[0] = c_mem[0];
    for (int k = 1; k < nb; k++) begin
      cmat_mul(m_mem[k-1], c_mem[k], n, t);
      cmat_mul(fwd[k-1], t, n, fwd[k]);
    end
    for (int i = 0; i < ELEMS; i++) begin
      bwd[i].re = 0;
      bwd[i].im = 0;
    end
    for (int i = 0; i < n; i++) bwd[i*MAX_STATES+i].re = int'(Q_ONE);
    for (int k = nb - 1; k >= 0; k--) begin
      cmat_mul(fwd[k], dm_mem[k], n, t);
      add_real_part(t, bwd, n);
      if (k > 0) begin
        cmat_mul(c_mem[k], m_mem[k], n, t);
        cmat_mul(t, bwd, n, u);
        bwd = u;
      end
    end
    for (int i = 0; i < n; i++) tr = clamp_add(tr, real_sum[i*MAX_STATES+i]);
    res.trace_re = tr;
    res.overflow = sat_seen;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      dim_reg = MAX_STATES;
      bead_reg = MAX_BEADS;
      errors = 0;
      trace_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_STATES) dim_reg = 32'(pwdata[2:0]);
        else if (paddr == ADDR_BEADS) bead_reg = 32'(pwdata[3:0]);
      end
      if (out_valid && !out_stall) begin
        if (trace_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result trace_re=%h overflow=%b", $time,
                   out_data.trace_re, out_data.overflow);
        end else begin
          want = trace_q.pop_front();
          if (out_data.trace_re !== want.trace_re) begin
            errors++;
            $display("%0t: trace_re expected %h actual %h", $time,
                     want.trace_re, out_data.trace_re);
          end
          if (out_data.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %b actual %b", $time,
                     want.overflow, out_data.overflow);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.func)
          FUNC_C: begin
            c_mem[in_data.bead_index][in_data.row_index*MAX_STATES+in_data.col_index] =
              '{in_data.elem_re, in_data.elem_im};
          end
          FUNC_M: begin
            m_mem[in_data.bead_index][in_data.row_index*MAX_STATES+in_data.col_index] =
              '{in_data.elem_re, in_data.elem_im};
          end
          FUNC_DM: begin
            dm_mem[in_data.bead_index][in_data.row_index*MAX_STATES+in_data.col_index] =
              '{in_data.elem_re, in_data.elem_im};
          end
          default: ;
        endcase
        if (in_data.last) trace_q.push_back(chain_trace());
      end
      pending = trace_q.size();
    end
  end

endmodule

@@ bench/tb_matrix_chain_trace_derivative.sv @@
// Top of the matrix_chain_trace_derivative bench: clock, reset, element and
// register stimulus, result-side stalls and the verdict. Uses mctd_checker.
module tb_matrix_chain_trace_derivative;
  import mctd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_STATES = 3'd0;
  localparam logic [2:0] ADDR_BEADS  = 3'd4;
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int SETTLE_CYC = 40;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_PHASES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int errors;
  int pending;
  int cycles = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int hold_left = 0;

  const int dim_set[NUM_PHASES]  = '{1, 2, 4, 0, 7, 3, 4, 2, 1, 4};
  const int bead_set[NUM_PHASES] = '{1, 3, 8, 0, 15, 5, 2, 8, 6, 4};

  matrix_chain_trace_derivative dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mctd_checker #(.ADDR_STATES(ADDR_STATES), .ADDR_BEADS(ADDR_BEADS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold) begin
      long_hold <= 1'b0;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (quiet || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      hold_left <= idle_len();
      out_stall <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 262144) - 131072;
    if (r < 85) return $urandom_range(0, 2097152) - 1048576;
    if (r < 95) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0001_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic in_item_t elem_item(logic [1:0] f, logic is_last);
    in_item_t it;
    it.func = f;
    it.bead_index = 3'($urandom);
    it.row_index = 2'($urandom);
    it.col_index = 2'($urandom);
    it.elem_re = rand_elem();
    it.elem_im = rand_elem();
    it.last = is_last;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let the checker count the last accepted transaction before polling pending
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int budget;
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every entry of all three families so no run reads an unwritten one
    for (int f = 0; f < 3; f++) begin
      for (int b = 0; b < MAX_BEADS; b++) begin
        for (int e = 0; e < ELEMS; e++) begin
          it = elem_item(2'(f), 1'b0);
          it.bead_index = 3'(b);
          it.row_index = 2'(e / MAX_STATES);
          it.col_index = 2'(e % MAX_STATES);
          it.last = (f == 2 && b == MAX_BEADS - 1 && e == ELEMS - 1);
          send(it);
        end
      end
    end

    // directed: extreme elements, each function with last, unused code, repeats
    it = elem_item(FUNC_C, 1'b1);
    it.elem_re = 32'h7fff_ffff;
    it.elem_im = 32'h7fff_ffff;
    send(it);
    it = elem_item(FUNC_M, 1'b1);
    it.elem_re = 32'h8000_0000;
    it.elem_im = 32'h8000_0000;
    send(it);
    it = elem_item(FUNC_DM, 1'b1);
    it.elem_re = 32'h0;
    it.elem_im = 32'hffff_ffff;
    send(it);
    it = elem_item(FUNC_NONE, 1'b1);
    send(it);
    send(it);
    for (int i = 0; i < 6; i++) send(elem_item(2'($urandom_range(0, 2)), 1'b0));
    it = elem_item(FUNC_NONE, 1'b1);
    it.bead_index = 3'h7;
    it.row_index = 2'h3;
    it.col_index = 2'h3;
    it.elem_re = 32'h8000_0000;
    it.elem_im = 32'h7fff_ffff;
    send(it);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      reg_write(ADDR_STATES, ($urandom & ~32'h7) | 32'(dim_set[p]));
      reg_write(ADDR_BEADS, ($urandom & ~32'hf) | 32'(bead_set[p]));
      quiet = (p % 3 == 0);
      if (p == 2 || p == 7) long_hold <= 1'b1;
      budget = 130;
      while (budget > 0) begin
        if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) send(elem_item(2'($urandom_range(0, 2)), 1'b0));
          it = elem_item(2'($urandom_range(0, 3)), 1'b1);
          send(it);
          budget -= len + 1;
        end else begin
          send(elem_item(2'($urandom), ($urandom_range(0, 3) == 0)));
          budget--;
        end
      end
      send(elem_item(2'($urandom_range(0, 2)), 1'b1));
      drain_results();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
